### rtl/easter_holy_days_calculator_macros.svh
// Assertion macros shared by the Easter holy days calculator RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef EASTER_HOLY_DAYS_CALCULATOR_MACROS_SVH
`define EASTER_HOLY_DAYS_CALCULATOR_MACROS_SVH

`ifndef SYNTHESIS

`define EHD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define EHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EHD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define EHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ehd_pkg.sv
// Shared types, feast codes, calendar tables and the day-number to date conversion.
// No dependencies.
package ehd_pkg;

    localparam int FEAST_COUNT = 5;

    localparam logic [2:0] FEAST_EASTER      = 3'd0;
    localparam logic [2:0] FEAST_CARNIVAL    = 3'd1;
    localparam logic [2:0] FEAST_GOOD_FRIDAY = 3'd2;
    localparam logic [2:0] FEAST_WHITSUNTIDE = 3'd3;
    localparam logic [2:0] FEAST_ASCENSION   = 3'd4;
    localparam logic [2:0] FEAST_LAST        = FEAST_ASCENSION;

    // Offsets from Easter, two's complement in 9 bits.
    localparam logic [8:0] FEAST_OFFSET [FEAST_COUNT] = '{
        9'd0,
        9'd463,
        9'd510,
        9'd49,
        9'd39
    };

    localparam int MONTH_COUNT = 12;

    // Day number of the last day of the previous month, common year.
    localparam logic [8:0] CUM_DAYS [MONTH_COUNT] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [7:0] doy;
        logic       leap;
    } ehd_date_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } ehd_md_t;

    function automatic ehd_md_t date_of(input logic [8:0] dn, input logic leap);
        ehd_md_t    md;
        logic [8:0] bound;
        logic [8:0] base;
        logic [8:0] rem;
        logic [3:0] mon;
        base = 9'd0;
        mon  = 4'd1;
        for (int m = 1; m < MONTH_COUNT; m++)
        begin
            bound = CUM_DAYS[4'(m)] + ((m >= 2) ? {8'd0, leap} : 9'd0);
            if (dn > bound)
            begin
                mon  = 4'(m + 1);
                base = bound;
            end
        end
        rem      = dn - base;
        md.month = mon;
        md.day   = (rem > 9'd31) ? 5'd31 : rem[4:0];
        return md;
    endfunction

endpackage

### rtl/ehd_computus.sv
// Nine-stage pipeline: year to day of year of Easter Sunday plus leap flag.
// Depends on ehd_pkg; constant divisions are reciprocal multiplies.
module ehd_computus
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [13:0]       year,
    output logic              dn_valid,
    input  logic              dn_ready,
    output ehd_pkg::ehd_date_t dn_data
);
    import ehd_pkg::*;

    localparam int STAGES = 9;

    typedef struct packed {
        logic [13:0] y;
        logic [7:0]  q100;
        logic [9:0]  q19;
    } s1_t;

    typedef struct packed {
        logic [4:0] a;
        logic [7:0] b;
        logic [6:0] c;
        logic       leap;
    } s2_t;

    typedef struct packed {
        logic [4:0] a;
        logic [7:0] b;
        logic [5:0] d;
        logic [1:0] e;
        logic [2:0] f;
        logic [4:0] i;
        logic [1:0] k;
        logic       leap;
    } s3_t;

    typedef struct packed {
        logic [4:0] a;
        logic [7:0] b;
        logic [5:0] d;
        logic [1:0] e;
        logic [4:0] i;
        logic [1:0] k;
        logic [5:0] g;
        logic       leap;
    } s4_t;

    typedef struct packed {
        logic [4:0] a;
        logic [1:0] e;
        logic [4:0] i;
        logic [1:0] k;
        logic [9:0] hsum;
        logic       leap;
    } s5_t;

    typedef struct packed {
        logic [4:0] a;
        logic [1:0] e;
        logic [4:0] i;
        logic [1:0] k;
        logic [4:0] h;
        logic       leap;
    } s6_t;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] h;
        logic [6:0] lsum;
        logic       leap;
    } s7_t;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] h;
        logic [2:0] l;
        logic       leap;
    } s8_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;

    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    s4_t       s4_reg, s4_next;
    s5_t       s5_reg, s5_next;
    s6_t       s6_reg, s6_next;
    s7_t       s7_reg, s7_next;
    s8_t       s8_reg, s8_next;
    ehd_date_t s9_reg, s9_next;

    logic [26:0] prod100;
    logic [29:0] prod19;
    logic [13:0] c_wide;
    logic [13:0] a_wide;
    logic [14:0] fprod;
    logic [7:0]  gx;
    logic [15:0] gprod;
    logic [19:0] hprod;
    logic [9:0]  h_wide;
    logic [14:0] lprod;
    logic [6:0]  l_wide;
    logic [8:0]  msum;
    logic        m;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || dn_ready;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = up_valid;
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (en[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    assign up_ready = en[0];
    assign dn_valid = valid_reg[STAGES-1];
    assign dn_data  = s9_reg;

    // stage 1: quotients by 100 and 19
    always_comb
    begin
        prod100      = 27'(year) * 27'd5243;
        prod19       = 30'(year) * 30'd55189;
        s1_next.y    = year;
        s1_next.q100 = prod100[26:19];
        s1_next.q19  = prod19[29:20];
    end

    // stage 2: remainders and leap rule
    always_comb
    begin
        c_wide       = s1_reg.y - 14'(s1_reg.q100) * 14'd100;
        a_wide       = s1_reg.y - 14'(s1_reg.q19) * 14'd19;
        s2_next.a    = a_wide[4:0];
        s2_next.b    = s1_reg.q100;
        s2_next.c    = c_wide[6:0];
        s2_next.leap = (s1_reg.y[1:0] == 2'd0)
                       && !((c_wide[6:0] == 7'd0) && (s1_reg.q100[1:0] != 2'd0));
    end

    // stage 3: d, e, f, i, k
    always_comb
    begin
        fprod        = 15'({1'b0, s2_reg.b} + 9'd8) * 15'd41;
        s3_next.a    = s2_reg.a;
        s3_next.b    = s2_reg.b;
        s3_next.d    = s2_reg.b[7:2];
        s3_next.e    = s2_reg.b[1:0];
        s3_next.f    = fprod[12:10];
        s3_next.i    = s2_reg.c[6:2];
        s3_next.k    = s2_reg.c[1:0];
        s3_next.leap = s2_reg.leap;
    end

    // stage 4: g = (b - f + 1) / 3
    always_comb
    begin
        gx           = s3_reg.b - 8'(s3_reg.f) + 8'd1;
        gprod        = 16'(gx) * 16'd171;
        s4_next.a    = s3_reg.a;
        s4_next.b    = s3_reg.b;
        s4_next.d    = s3_reg.d;
        s4_next.e    = s3_reg.e;
        s4_next.i    = s3_reg.i;
        s4_next.k    = s3_reg.k;
        s4_next.g    = gprod[14:9];
        s4_next.leap = s3_reg.leap;
    end

    // stage 5: sum ahead of mod 30
    always_comb
    begin
        s5_next.a    = s4_reg.a;
        s5_next.e    = s4_reg.e;
        s5_next.i    = s4_reg.i;
        s5_next.k    = s4_reg.k;
        s5_next.hsum = 10'(s4_reg.a) * 10'd19 + 10'(s4_reg.b) - 10'(s4_reg.d)
                       - 10'(s4_reg.g) + 10'd15;
        s5_next.leap = s4_reg.leap;
    end

    // stage 6: h = hsum mod 30
    always_comb
    begin
        hprod        = 20'(s5_reg.hsum) * 20'd547;
        h_wide       = s5_reg.hsum - 10'(hprod[18:14]) * 10'd30;
        s6_next.a    = s5_reg.a;
        s6_next.e    = s5_reg.e;
        s6_next.i    = s5_reg.i;
        s6_next.k    = s5_reg.k;
        s6_next.h    = h_wide[4:0];
        s6_next.leap = s5_reg.leap;
    end

    // stage 7: sum ahead of mod 7
    always_comb
    begin
        s7_next.a    = s6_reg.a;
        s7_next.h    = s6_reg.h;
        s7_next.lsum = 7'd67 + 7'({s6_reg.e, 1'b0}) + 7'({s6_reg.i, 1'b0})
                       - 7'(s6_reg.h) - 7'(s6_reg.k);
        s7_next.leap = s6_reg.leap;
    end

    // stage 8: l = lsum mod 7
    always_comb
    begin
        lprod        = 15'(s7_reg.lsum) * 15'd147;
        l_wide       = s7_reg.lsum - 7'(lprod[14:10]) * 7'd7;
        s8_next.a    = s7_reg.a;
        s8_next.h    = s7_reg.h;
        s8_next.l    = l_wide[2:0];
        s8_next.leap = s7_reg.leap;
    end

    // stage 9: m and day of year; March and April both reduce to v - 33 + leap
    always_comb
    begin
        msum         = 9'(s8_reg.a) + 9'(s8_reg.h) * 9'd11 + 9'(s8_reg.l) * 9'd22;
        m            = (msum >= 9'd451);
        s9_next.doy  = 8'(s8_reg.h) + 8'(s8_reg.l) + 8'd81 + 8'(s8_reg.leap)
                       - (m ? 8'd7 : 8'd0);
        s9_next.leap = s8_reg.leap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
        if (en[3]) s4_reg <= s4_next;
        if (en[4]) s5_reg <= s5_next;
        if (en[5]) s6_reg <= s6_next;
        if (en[6]) s7_reg <= s7_next;
        if (en[7]) s8_reg <= s8_next;
        if (en[8]) s9_reg <= s9_next;
    end

endmodule

### rtl/ehd_serializer.sv
// Expands one Easter day of year into five registered feast dates and takes the next request
// as the last one goes out. Depends on ehd_pkg and the assertion macros.
`include "easter_holy_days_calculator_macros.svh"

module ehd_serializer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  ehd_pkg::ehd_date_t up_data,
    output logic               feast_valid,
    input  logic               feast_stall,
    output logic [2:0]         feast,
    output logic [3:0]         month_number,
    output logic [4:0]         day_of_month,
    output logic               last_of_run
);
    import ehd_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] k_reg, k_next;
    ehd_date_t  date_reg;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] feast_reg;
    logic [3:0] month_reg;
    logic [4:0] day_reg;
    logic       last_reg;

    logic       load;
    logic       emit;
    logic       take;
    logic       at_last;
    logic [8:0] dn;
    ehd_md_t    md;

    assign load    = !out_valid_reg || !feast_stall;
    assign emit    = busy_reg && load;
    assign at_last = (k_reg == FEAST_LAST);
    assign up_ready = !busy_reg || (emit && at_last);
    assign take    = up_valid && up_ready;

    assign dn = {1'b0, date_reg.doy} + FEAST_OFFSET[k_reg];
    assign md = date_of(dn, date_reg.leap);

    always_comb
    begin
        busy_next      = busy_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            k_next = k_reg + 3'd1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            k_next    = FEAST_EASTER;
        end
        if (load)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= FEAST_EASTER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            date_reg <= up_data;
        end
        if (emit)
        begin
            feast_reg <= k_reg;
            month_reg <= md.month;
            day_reg   <= md.day;
            last_reg  <= at_last;
        end
    end

    assign feast_valid  = out_valid_reg;
    assign feast        = feast_reg;
    assign month_number = month_reg;
    assign day_of_month = day_reg;
    assign last_of_run  = last_reg;

    `EHD_ASSERT_IMPLY(a_month_range, clk, rst_n, out_valid_reg,
        (month_reg >= 4'd2) && (month_reg <= 4'd6) && (day_reg != 5'd0),
        "feast date outside February to June")

    `EHD_ASSERT_NEXT(a_feast_advance, clk, rst_n, emit && !at_last,
        busy_reg && (k_reg == $past(k_reg) + 3'd1),
        "feast sequence did not advance")

    `EHD_ASSERT_NEXT(a_take_start, clk, rst_n, take,
        busy_reg && (k_reg == FEAST_EASTER) && (date_reg == $past(up_data)),
        "new request not captured at Easter")

endmodule

### rtl/easter_holy_days_calculator.sv
// Path: a taken year passes the computus stages, then the serializer date and output registers.
// Throughput: one year per five feast results, issued one per cycle unless feast_stall holds.
// The 9-stage date pipeline takes a year per cycle until full, holding years while output drains.
// Reset: rst_n asynchronous, active low; clears valid bits and the feast counter.
// Depends on ehd_pkg, ehd_computus and ehd_serializer.
module easter_holy_days_calculator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        year_valid,
    output logic        year_stall,
    input  logic [13:0] year,
    output logic        feast_valid,
    input  logic        feast_stall,
    output logic [2:0]  feast,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic        last_of_run
);
    import ehd_pkg::*;

    logic      up_ready;
    logic      date_valid;
    logic      date_ready;
    ehd_date_t date;

    assign year_stall = !up_ready;

    ehd_computus u_computus
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (year_valid),
        .up_ready (up_ready),
        .year     (year),
        .dn_valid (date_valid),
        .dn_ready (date_ready),
        .dn_data  (date)
    );

    ehd_serializer u_serializer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (date_valid),
        .up_ready     (date_ready),
        .up_data      (date),
        .feast_valid  (feast_valid),
        .feast_stall  (feast_stall),
        .feast        (feast),
        .month_number (month_number),
        .day_of_month (day_of_month),
        .last_of_run  (last_of_run)
    );

endmodule
